// ===== rtl/core/rtb_pkg.sv =====
// Shared types and constants for the repeating timer bank.
package rtb_pkg;

    localparam int unsigned MAX_RESULTS = 8;
    localparam int unsigned NRES_W      = 4;
    localparam logic [15:0] REPEAT_FOREVER = 16'hFFFF;

    localparam logic KIND_ADD  = 1'b0;
    localparam logic KIND_TICK = 1'b1;

    typedef enum logic [1:0] {
        RES_ADDED = 2'd0,
        RES_FULL  = 2'd1,
        RES_TICK  = 2'd2,
        RES_EMIT  = 2'd3
    } rtb_res_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ADD,
        ST_SCAN,
        ST_EXEC
    } rtb_state_t;

    typedef struct packed {
        logic [15:0] repeats;
        logic [15:0] period;
        logic [15:0] count;
    } rtb_entry_t;

endpackage

// ===== rtl/core/repeating_timer_bank_core.sv =====
// Top level of the repeating timer bank: sequencer, slot flags and result register.
//
//  channel | dir | fields (low bit up)                         | side info
//  s_axis  | in  | tdata: period[15:0], repeat_count[31:16]    | tuser: kind
//  m_axis  | out | tdata: slot[2:0], count[18:3], zero pad     | tuser: result_kind, tlast: last
//
// An add is accepted in IDLE and claims its slot in ADD. A tick is accepted in IDLE and
// then walks every slot in SCAN; each running slot also passes through EXEC, its store
// entry being read in SCAN and updated in EXEC through the store's write port. A full
// result register holds an add, and holds the walk at a running slot unless MAX_RESULTS
// results have already been issued for this tick.
// Reset clears the active and paused flags at once; store entries are written by add.
module repeating_timer_bank_core
    import rtb_pkg::*;
#(
    parameter int SLOT_COUNT = 8
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // period[15:0], repeat_count[31:16]
    input  logic        s_tuser,   // kind
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // slot[2:0], count[18:3], zeros[23:19]
    output logic [1:0]  m_tuser,   // result_kind
    output logic        m_tlast
);

    localparam int IW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int SW = (IW > 3) ? IW : 3;

    rtb_state_t             state_reg, state_next;
    logic [IW-1:0]          idx_reg, idx_next;
    logic [NRES_W-1:0]      nres_reg, nres_next;
    logic [15:0]            per_reg, per_next;
    logic [15:0]            rep_reg, rep_next;
    logic [SLOT_COUNT-1:0]  active_reg, active_next;
    logic [SLOT_COUNT-1:0]  paused_reg, paused_next;

    logic                   m_valid_reg, m_valid_next;
    rtb_res_t               m_kind_reg, m_kind_next;
    logic [2:0]             m_slot_reg, m_slot_next;
    logic [15:0]            m_count_reg, m_count_next;
    logic                   m_last_reg, m_last_next;

    logic                   wr_en;
    logic [IW-1:0]          wr_addr;
    rtb_entry_t             wr_data;
    rtb_entry_t             rd_data;

    logic                   can_load;
    logic                   capped;
    logic                   idx_last;
    logic [SLOT_COUNT-1:0]  elig;
    logic                   any_later;
    logic                   any_free;
    logic [IW-1:0]          free_idx;
    logic [SW-1:0]          idx_ext;
    logic [SW-1:0]          free_ext;
    logic                   exec_go;

    rtb_store #(
        .DEPTH (SLOT_COUNT),
        .AW    (IW)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (idx_reg),
        .rd_data (rd_data)
    );

    assign can_load = !m_valid_reg || m_tready;
    assign capped   = (nres_reg == NRES_W'(MAX_RESULTS));
    assign idx_last = (idx_reg == IW'(SLOT_COUNT - 1));
    assign elig     = active_reg & ~paused_reg;
    assign exec_go  = can_load || capped;
    assign idx_ext  = SW'(idx_reg);
    assign free_ext = SW'(free_idx);

    // Later slots keep their flags during the walk, so they tell whether more results follow.
    always_comb
    begin
        any_later = 1'b0;
        for (int j = 0; j < SLOT_COUNT; j++)
        begin
            if ((IW'(j) > idx_reg) && elig[j])
            begin
                any_later = 1'b1;
            end
        end
    end

    // Lowest inactive slot.
    always_comb
    begin
        any_free = 1'b0;
        free_idx = '0;
        for (int j = SLOT_COUNT - 1; j >= 0; j--)
        begin
            if (!active_reg[j])
            begin
                any_free = 1'b1;
                free_idx = IW'(j);
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = (s_tuser == KIND_ADD) ? ST_ADD : ST_SCAN;
                end
            end
            ST_ADD:
            begin
                if (can_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_SCAN:
            begin
                if (elig[idx_reg])
                begin
                    state_next = ST_EXEC;
                end
                else if (idx_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_EXEC:
            begin
                if (exec_go)
                begin
                    state_next = idx_last ? ST_IDLE : ST_SCAN;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        idx_next     = idx_reg;
        nres_next    = nres_reg;
        per_next     = per_reg;
        rep_next     = rep_reg;
        active_next  = active_reg;
        paused_next  = paused_reg;
        m_valid_next = m_valid_reg && !m_tready;
        m_kind_next  = m_kind_reg;
        m_slot_next  = m_slot_reg;
        m_count_next = m_count_reg;
        m_last_next  = m_last_reg;
        wr_en        = 1'b0;
        wr_addr      = idx_reg;
        wr_data      = rd_data;
        s_tready     = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    per_next  = s_tdata[15:0];
                    rep_next  = s_tdata[31:16];
                    idx_next  = '0;
                    nres_next = '0;
                end
            end
            ST_ADD:
            begin
                if (can_load)
                begin
                    m_valid_next = 1'b1;
                    m_last_next  = 1'b1;
                    m_count_next = '0;
                    if (any_free)
                    begin
                        m_kind_next           = RES_ADDED;
                        m_slot_next           = free_ext[2:0];
                        wr_en                 = 1'b1;
                        wr_addr               = free_idx;
                        wr_data.count         = '0;
                        wr_data.period        = per_reg;
                        wr_data.repeats       = rep_reg;
                        active_next[free_idx] = 1'b1;
                        paused_next[free_idx] = 1'b0;
                    end
                    else
                    begin
                        m_kind_next = RES_FULL;
                        m_slot_next = '0;
                    end
                end
            end
            ST_SCAN:
            begin
                if (!elig[idx_reg] && !idx_last)
                begin
                    idx_next = idx_reg + IW'(1);
                end
            end
            ST_EXEC:
            begin
                if (exec_go)
                begin
                    wr_en = 1'b1;
                    if (rd_data.count < rd_data.period)
                    begin
                        wr_data.count = rd_data.count + 16'd1;
                        m_kind_next   = RES_TICK;
                    end
                    else
                    begin
                        m_kind_next = RES_EMIT;
                        if (rd_data.repeats != 16'd0)
                        begin
                            wr_data.count = '0;
                            if (rd_data.repeats != REPEAT_FOREVER)
                            begin
                                wr_data.repeats = rd_data.repeats - 16'd1;
                            end
                        end
                        else
                        begin
                            paused_next[idx_reg] = 1'b1;
                        end
                    end
                    if (!capped)
                    begin
                        m_valid_next = 1'b1;
                        m_slot_next  = idx_ext[2:0];
                        m_count_next = wr_data.count;
                        m_last_next  = !any_later
                                       || (nres_reg == NRES_W'(MAX_RESULTS - 1));
                        nres_next    = nres_reg + NRES_W'(1);
                    end
                    else
                    begin
                        m_kind_next = m_kind_reg;
                    end
                    if (!idx_last)
                    begin
                        idx_next = idx_reg + IW'(1);
                    end
                end
            end
            default:
            begin
                s_tready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            idx_reg     <= '0;
            nres_reg    <= '0;
            active_reg  <= '0;
            paused_reg  <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            idx_reg     <= idx_next;
            nres_reg    <= nres_next;
            active_reg  <= active_next;
            paused_reg  <= paused_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        per_reg     <= per_next;
        rep_reg     <= rep_next;
        m_kind_reg  <= m_kind_next;
        m_slot_reg  <= m_slot_next;
        m_count_reg <= m_count_next;
        m_last_reg  <= m_last_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_kind_reg;
    assign m_tlast  = m_last_reg;
    assign m_tdata  = {5'd0, m_count_reg, m_slot_reg};

endmodule

// ===== rtl/core/rtb_store.sv =====
// Slot store: count, period and repeats per slot, one write and one registered read.
module rtb_store
    import rtb_pkg::*;
#(
    parameter int DEPTH = 8,
    parameter int AW    = 3
)
(
    input  logic              clk,
    input  logic              wr_en,
    input  logic [AW-1:0]     wr_addr,
    input  rtb_entry_t        wr_data,
    input  logic [AW-1:0]     rd_addr,
    output rtb_entry_t        rd_data
);

    rtb_entry_t mem [DEPTH];
    rtb_entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== test/repeating_timer_bank_core_tb.sv =====
// Self-checking testbench for the repeating timer bank core.
`timescale 1ns / 1ps

module repeating_timer_bank_core_tb;
    import rtb_pkg::*;

    localparam real CLK_PERIOD     = 4.0;
    localparam int  SLOTS          = 8;
    localparam int  LONG_HOLD      = 300;
    localparam int  WATCHDOG_LIMIT = 4000;
    localparam int  DRAIN_CYCLES   = 40;
    localparam int  MAX_PRINTED    = 40;

    typedef struct packed {
        rtb_res_t    kind;
        logic [2:0]  slot;
        logic [15:0] count;
        logic        last;
    } timer_event_t;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata  = 32'd0;   // period[15:0], repeat_count[31:16]
    logic        s_tuser  = 1'b0;    // kind
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;            // slot[2:0], count[18:3], zeros[23:19]
    logic [1:0]  m_tuser;            // result_kind
    logic        m_tlast;

    // shadow copy of the timer slots
    logic        tmr_active  [SLOTS];
    logic        tmr_paused  [SLOTS];
    logic [15:0] tmr_count   [SLOTS];
    logic [15:0] tmr_period  [SLOTS];
    logic [15:0] tmr_repeats [SLOTS];

    timer_event_t expected_events[$];

    bit src_bursty      = 1'b1;
    bit sink_bursty     = 1'b1;
    int hold_requests   = 0;
    int hold_served     = 0;
    int sink_stall_left = 0;
    int idle_cycles     = 0;
    int err_count       = 0;
    int results_seen    = 0;
    int adds_sent       = 0;
    int full_seen       = 0;
    int ticks_sent      = 0;
    int emits_seen      = 0;

    repeating_timer_bank_core #(
        .SLOT_COUNT (SLOTS)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (err_count < MAX_PRINTED)
            $display("ERROR @%0t result %0d: %s got %0h want %0h",
                     $time, results_seen, what, got, want);
        err_count++;
    endtask

    // Apply one accepted item to the shadow slots and queue the results it causes.
    function automatic void advance_timers(input logic kind, input logic [15:0] period,
                                           input logic [15:0] reps);
        timer_event_t ev;
        timer_event_t held;
        bit           have_held;
        bit           placed;
        int           produced;
        rtb_res_t     rk;
        have_held = 1'b0;
        placed    = 1'b0;
        produced  = 0;
        if (kind == KIND_ADD) begin
            adds_sent++;
            for (int i = 0; i < SLOTS; i++) begin
                if (!placed && !tmr_active[i]) begin
                    tmr_active[i]  = 1'b1;
                    tmr_paused[i]  = 1'b0;
                    tmr_count[i]   = 16'd0;
                    tmr_period[i]  = period;
                    tmr_repeats[i] = reps;
                    ev = '{RES_ADDED, 3'(i), 16'd0, 1'b1};
                    placed = 1'b1;
                end
            end
            if (!placed) begin
                ev = '{RES_FULL, 3'd0, 16'd0, 1'b1};
                full_seen++;
            end
            expected_events.push_back(ev);
        end else begin
            ticks_sent++;
            for (int i = 0; i < SLOTS; i++) begin
                if (tmr_active[i] && !tmr_paused[i]) begin
                    if (tmr_count[i] < tmr_period[i]) begin
                        tmr_count[i] = tmr_count[i] + 16'd1;
                        rk = RES_TICK;
                    end else begin
                        rk = RES_EMIT;
                        emits_seen++;
                        if (tmr_repeats[i] != 16'd0) begin
                            tmr_count[i] = 16'd0;
                            if (tmr_repeats[i] != REPEAT_FOREVER)
                                tmr_repeats[i] = tmr_repeats[i] - 16'd1;
                        end else begin
                            tmr_paused[i] = 1'b1;
                        end
                    end
                    if (produced < MAX_RESULTS) begin
                        // hold one back so the final one can carry last
                        if (have_held)
                            expected_events.push_back(held);
                        held      = '{rk, 3'(i), tmr_count[i], 1'b0};
                        have_held = 1'b1;
                        produced++;
                    end
                end
            end
            if (have_held) begin
                held.last = 1'b1;
                expected_events.push_back(held);
            end
        end
    endfunction

    task automatic send_item(input logic kind, input logic [15:0] period,
                             input logic [15:0] reps);
        int gap;
        if (src_bursty && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 11);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {reps, period};
        do @(posedge clk); while (!s_tready);
        advance_timers(kind, period, reps);
    endtask

    task automatic send_tick();
        send_item(KIND_TICK, 16'($urandom), 16'($urandom));
    endtask

    // Result checker: compare every transfer with the oldest expectation.
    always @(posedge clk) begin
        timer_event_t want;
        if (rst_n && m_tvalid && m_tready) begin
            results_seen++;
            if (expected_events.size() == 0) begin
                report_mismatch("unexpected result", {m_tuser, m_tlast, 5'd0, m_tdata}, 0);
            end else begin
                want = expected_events.pop_front();
                if (m_tuser !== want.kind)
                    report_mismatch("result_kind", m_tuser, want.kind);
                if (m_tdata[2:0] !== want.slot)
                    report_mismatch("slot", m_tdata[2:0], want.slot);
                if (m_tdata[18:3] !== want.count)
                    report_mismatch("count", m_tdata[18:3], want.count);
                if (m_tdata[23:19] !== 5'd0)
                    report_mismatch("tdata pad", m_tdata[23:19], 0);
                if (m_tlast !== want.last)
                    report_mismatch("last", m_tlast, want.last);
            end
        end
    end

    // Receiver: random stalls, plus a long hold when one is requested.
    always @(posedge clk) begin
        if (hold_served != hold_requests) begin
            hold_served     <= hold_requests;
            sink_stall_left <= LONG_HOLD;
            m_tready        <= 1'b0;
        end else if (sink_stall_left != 0) begin
            sink_stall_left <= sink_stall_left - 1;
            m_tready        <= 1'b0;
        end else if (sink_bursty && $urandom_range(0, 7) == 0) begin
            sink_stall_left <= $urandom_range(0, 10);
            m_tready        <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Watchdog: end the run if no transfer happens on either side for too long.
    always @(posedge clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no transfer for %0d cycles, %0d results still pending",
                     idle_cycles, expected_events.size());
            $display("repeating_timer_bank_core: mismatch");
            $finish;
        end
    end

    task automatic test_empty_tick();
        // nothing is running yet, so no result
        send_tick();
    endtask

    task automatic test_directed_slots();
        send_item(KIND_ADD, 16'd0,     16'd0);      // emits on first tick, then pauses
        send_item(KIND_ADD, 16'd2,     16'hFFFF);   // repeats forever
        send_item(KIND_ADD, 16'd1,     16'h8000);   // repeats 32768, down to 32767 after the first emit
        send_item(KIND_ADD, 16'hFFFF,  16'h7FFF);   // widest period, repeats 32767
        send_item(KIND_ADD, 16'd3,     16'd1);      // emits twice, then pauses
        repeat (11) send_tick();
    endtask

    task automatic test_backpressure();
        src_bursty = 1'b0;
        hold_requests++;
        repeat (24) send_tick();
        src_bursty = 1'b1;
    endtask

    function automatic logic [15:0] pick_repeats();
        case ($urandom_range(0, 5))
            0:       return REPEAT_FOREVER;
            1:       return 16'd0;
            2:       return 16'h8000;
            3:       return 16'($urandom_range(1, 5));
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic test_random_mix(input int items);
        logic [15:0] period;
        for (int n = 0; n < items; n++) begin
            if ($urandom_range(0, 4) == 0) begin
                period = ($urandom_range(0, 7) == 0) ? 16'($urandom)
                                                     : 16'($urandom_range(0, 7));
                send_item(KIND_ADD, period, pick_repeats());
            end else begin
                send_tick();
            end
        end
    endtask

    task automatic test_steady_tail();
        src_bursty  = 1'b0;
        sink_bursty = 1'b0;
        test_random_mix(20);
    endtask

    initial begin
        int drain;
        for (int i = 0; i < SLOTS; i++) begin
            tmr_active[i] = 1'b0;
            tmr_paused[i] = 1'b0;
        end
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_tick();
        test_directed_slots();
        test_backpressure();
        test_random_mix(400);
        test_steady_tail();

        s_tvalid <= 1'b0;
        while (expected_events.size() != 0)
            @(posedge clk);
        drain = DRAIN_CYCLES;
        repeat (drain) @(posedge clk);

        $display("covered %0d adds (%0d rejected as bank full) and %0d ticks",
                 adds_sent, full_seen, ticks_sent);
        $display("checked %0d results, %0d of them emits, with stalls on both sides",
                 results_seen, emits_seen);
        if (err_count == 0)
            $display("repeating_timer_bank_core: match");
        else
            $display("repeating_timer_bank_core: mismatch");
        $finish;
    end

endmodule
